// ----- design/u16u8_pkg.sv -----
package u16u8_pkg;

  localparam logic [15:0] SURR_LO     = 16'hd800;
  localparam logic [15:0] SURR_HI     = 16'hdfff;
  localparam logic [15:0] LOW_SURR_LO = 16'hdc00;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;
  localparam logic [20:0] MAX_1BYTE   = 21'h7f;
  localparam logic [20:0] MAX_2BYTE   = 21'h7ff;
  localparam logic [20:0] MAX_3BYTE   = 21'hffff;
  localparam logic [7:0]  LEAD_2BYTE  = 8'hc0;
  localparam logic [7:0]  LEAD_3BYTE  = 8'he0;
  localparam logic [7:0]  LEAD_4BYTE  = 8'hf0;
  localparam logic [7:0]  CONT_BYTE   = 8'h80;

  localparam logic [15:0] CAP_RESET   = 16'd256;

  // Bytes one code unit can produce: four encoded bytes plus the NUL.
  localparam int RUN_MAX = 5;
  localparam int CNT_W   = $clog2(RUN_MAX + 1);

  typedef logic [7:0] byte_t;

  // Pending output run, drained one word per cycle from slot 0 while m_tready is high.
  typedef struct packed {
    byte_t [RUN_MAX-1:0] bytes;
    logic [CNT_W-1:0]    cnt;
    logic                has_nul;
    logic [15:0]         total;
  } run_t;

endpackage

// ----- design/utf16_to_utf8_transcoder_top.sv -----
// UTF-16 to UTF-8 transcoder. Each input word is one UTF-16 code unit; a high
// surrogate followed by a low surrogate forms one supplementary code point,
// and every complete code point leaves as a run of 1 to 4 UTF-8 bytes, one
// byte per output word, with tlast on the final byte of the run. A zero unit
// or a unit with s_tlast set ends the string: a NUL word follows, flagged on
// tuser and carrying the byte count of the string. Lone low surrogates and
// broken pairs are dropped. Once a code point plus the NUL would overflow
// cfg capacity, the rest of the string is discarded; a capacity of zero
// emits nothing. Rate: with m_tready held high, units that yield zero or one
// output word flow at one unit per cycle; a unit that yields more than one
// output word (NUL included) holds the input while the output run register
// drains them one word per cycle, and the next unit is taken on the cycle its
// last word leaves. Write the capacity only while the block is idle.
module utf16_to_utf8_transcoder_top
  import u16u8_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration: output capacity in bytes, terminator included
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] code_unit
  input  logic        s_tlast,   // end_of_source
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] byte_total
  output logic        m_tlast,   // run_last
  output logic        m_tuser    // string_done
);

  // String state
  logic [15:0] capacity;
  logic        awaiting_low, awaiting_low_next;
  logic [20:0] partial_point, partial_point_next;
  logic [15:0] bytes_written, bytes_written_next;
  logic        output_full, output_full_next;

  run_t run, run_next;

  logic        accept, pop;
  logic [15:0] unit;
  logic        is_surr, is_high, is_low;
  logic        have_cp;
  logic [20:0] cp;
  logic [2:0]  len;
  logic        fits, emit, term, emit_nul;
  logic [17:0] need;
  byte_t [3:0] enc;
  logic [2:0]  nb;

  assign unit   = s_tdata;
  assign pop    = m_tvalid && m_tready;
  // Take a new word when the run register is empty or frees up this cycle.
  assign s_tready = (run.cnt == '0) || (run.cnt == CNT_W'(1) && m_tready);
  assign accept = s_tvalid && s_tready;

  assign is_surr = (unit >= SURR_LO) && (unit <= SURR_HI);
  assign is_low  = (unit >= LOW_SURR_LO) && (unit <= SURR_HI);
  assign is_high = is_surr && !is_low;

  // Surrogate pairing and code point assembly
  always_comb begin
    have_cp            = 1'b0;
    cp                 = '0;
    awaiting_low_next  = awaiting_low;
    partial_point_next = partial_point;
    if (unit != 16'd0) begin
      if (!awaiting_low) begin
        if (!is_surr) begin
          cp      = {5'd0, unit};
          have_cp = 1'b1;
        end else if (is_high) begin
          partial_point_next = {1'b0, unit[9:0], 10'd0} + SUPP_BASE;
          awaiting_low_next  = 1'b1;
        end
      end else begin
        awaiting_low_next = 1'b0;
        if (is_low) begin
          cp      = partial_point | {11'd0, unit[9:0]};
          have_cp = 1'b1;
        end
      end
    end
  end

  // Length, capacity check and byte encoding
  always_comb begin
    if (cp <= MAX_1BYTE)      len = 3'd1;
    else if (cp <= MAX_2BYTE) len = 3'd2;
    else if (cp <= MAX_3BYTE) len = 3'd3;
    else                      len = 3'd4;
  end

  assign need = {2'b00, bytes_written} + {15'd0, len} + 18'd1;
  assign fits = need <= {2'b00, capacity};

  always_comb begin
    enc = '0;
    case (len)
      3'd1: enc[0] = cp[7:0];
      3'd2: begin
        enc[0] = LEAD_2BYTE | {3'd0, cp[10:6]};
        enc[1] = CONT_BYTE  | {2'd0, cp[5:0]};
      end
      3'd3: begin
        enc[0] = LEAD_3BYTE | {4'd0, cp[15:12]};
        enc[1] = CONT_BYTE  | {2'd0, cp[11:6]};
        enc[2] = CONT_BYTE  | {2'd0, cp[5:0]};
      end
      default: begin
        enc[0] = LEAD_4BYTE | {5'd0, cp[20:18]};
        enc[1] = CONT_BYTE  | {2'd0, cp[17:12]};
        enc[2] = CONT_BYTE  | {2'd0, cp[11:6]};
        enc[3] = CONT_BYTE  | {2'd0, cp[5:0]};
      end
    endcase
  end

  always_comb begin
    emit               = have_cp && !output_full && fits;
    output_full_next   = output_full || (have_cp && !output_full && !fits);
    bytes_written_next = emit ? bytes_written + {13'd0, len} : bytes_written;
    nb                 = emit ? len : 3'd0;
    term               = (unit == 16'd0) || s_tlast;
    emit_nul           = term && (bytes_written_next < capacity);
  end

  // Build the next run: encoded bytes first, then zeros, so the NUL falls in
  // place right after the last encoded byte.
  always_comb begin
    run_next = run;
    if (pop) begin
      for (int k = 0; k < RUN_MAX - 1; k++) run_next.bytes[k] = run.bytes[k+1];
      run_next.bytes[RUN_MAX-1] = 8'd0;
      run_next.cnt = run.cnt - CNT_W'(1);
    end
    if (accept) begin
      for (int k = 0; k < RUN_MAX; k++) begin
        if (k < 4 && 3'(k) < nb) run_next.bytes[k] = enc[k[1:0]];
        else                     run_next.bytes[k] = 8'd0;
      end
      run_next.cnt     = CNT_W'(nb) + CNT_W'(emit_nul);
      run_next.has_nul = emit_nul;
      run_next.total   = bytes_written_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= CAP_RESET;
      awaiting_low  <= 1'b0;
      partial_point <= '0;
      bytes_written <= '0;
      output_full   <= 1'b0;
    end else begin
      if (cfg_wen) capacity <= cfg_wdata;
      if (accept) begin
        if (term) begin
          // string ends: drop any pending surrogate and start fresh
          awaiting_low  <= 1'b0;
          partial_point <= '0;
          bytes_written <= '0;
          output_full   <= 1'b0;
        end else begin
          awaiting_low  <= awaiting_low_next;
          partial_point <= partial_point_next;
          bytes_written <= bytes_written_next;
          output_full   <= output_full_next;
        end
      end
    end
  end

  // Run register: reset the count only; the payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      run.cnt <= '0;
    end else begin
      run.cnt <= run_next.cnt;
    end
    run.bytes   <= run_next.bytes;
    run.has_nul <= run_next.has_nul;
    run.total   <= run_next.total;
  end

  // Drive the output word from slot 0 of the run
  assign m_tvalid = run.cnt != '0;
  assign m_tlast  = run.cnt == CNT_W'(1);
  assign m_tuser  = m_tlast && run.has_nul;
  assign m_tdata  = {(m_tuser ? run.total : 16'd0), run.bytes[0]};

  // No new word while a multi-byte run still drains
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (run.cnt > CNT_W'(1)) |-> !s_tready)
    else $error("input taken while run still draining");

  // Run never exceeds four bytes plus the terminator
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    run.cnt <= CNT_W'(RUN_MAX))
    else $error("run count out of range");

  // Terminator closes its run and is a zero byte
  a_nul_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && m_tdata[7:0] == 8'd0))
    else $error("terminator not last or not zero");

  // Byte count is zero on all but the terminator
  a_total_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[23:8] == 16'd0))
    else $error("byte_total set on a data byte");

  // A word with results leaves a non-empty run behind
  a_load: assert property (@(posedge clk) disable iff (rst)
    (accept && (nb != 3'd0 || emit_nul)) |=> m_tvalid)
    else $error("accepted word produced no run");

endmodule
